/* hw/rtl/assert_macros.svh */
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

/* hw/rtl/lr_pkg.sv */
// Types and constants shared by the line rasterizer modules.
`default_nettype none

package lr_pkg;

	// Width of every coordinate field on the ports.
	localparam int LR_FIELD_W = 6;
	localparam int LR_COLOR_W = 4;

	// Request layout on s_tdata, lowest field first.
	localparam int LR_SX_LSB   = 0;
	localparam int LR_SY_LSB   = 6;
	localparam int LR_EX_LSB   = 12;
	localparam int LR_EY_LSB   = 18;
	localparam int LR_COL_LSB  = 24;
	localparam int LR_S_DATA_W = 32;

	// Point layout on m_tdata, lowest field first.
	localparam int LR_PX_LSB   = 0;
	localparam int LR_PY_LSB   = 6;
	localparam int LR_PC_LSB   = 12;
	localparam int LR_M_DATA_W = 16;

	typedef enum logic [0:0] {
		LR_IDLE,
		LR_EMIT
	} lr_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic step;
	} lr_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic last;
	} lr_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/line_rasterizer.sv */
// Top level of the line rasterizer: Bresenham line points from a line request.
//
//   channel  | dir | payload                                          | marker
//   ---------+-----+--------------------------------------------------+--------
//   s_axis   | in  | start_x, start_y, end_x, end_y, pen_color        | -
//   m_axis   | out | point_x, point_y, point_color                    | tlast
//
// A request is loaded, then N = max(|dx|,|dy|)+1 points (1 to 2^COORD_BITS)
// follow, one point per cycle from the single step unit of the datapath while
// m_axis does not stall. A stall on m_axis holds the current point.
// s_tready is high only while no request is in work. Reset clears the
// controller state; the datapath registers need none.
`default_nettype none

`include "assert_macros.svh"

module line_rasterizer
	import lr_pkg::*;
#(
	parameter int COORD_BITS = 6
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [5:0] start_x, [11:6] start_y, [17:12] end_x, [23:18] end_y,
	// [27:24] pen_color, [31:28] zero
	input  wire logic [LR_S_DATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [5:0] point_x, [11:6] point_y, [15:12] point_color
	output logic [LR_M_DATA_W-1:0]      m_tdata,
	// last_point
	output logic                        m_tlast
);

	lr_cmd_t  cmd;
	lr_stat_t stat;

	logic [COORD_BITS-1:0] pt_x, pt_y;
	logic [LR_COLOR_W-1:0] pt_color;

	// Controller: idle/emit sequencing and handshakes
	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.pt_valid  (m_tvalid),
		.pt_ready  (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath: coordinates wider than COORD_BITS drop their upper bits here
	lr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.start_x     (s_tdata[LR_SX_LSB +: COORD_BITS]),
		.start_y     (s_tdata[LR_SY_LSB +: COORD_BITS]),
		.end_x       (s_tdata[LR_EX_LSB +: COORD_BITS]),
		.end_y       (s_tdata[LR_EY_LSB +: COORD_BITS]),
		.pen_color   (s_tdata[LR_COL_LSB +: LR_COLOR_W]),
		.point_x     (pt_x),
		.point_y     (pt_y),
		.point_color (pt_color)
	);

	// Pack the point, zero-extending coordinates to the field width
	always_comb begin
		m_tdata = '0;
		m_tdata[LR_PX_LSB +: LR_FIELD_W] = LR_FIELD_W'(pt_x);
		m_tdata[LR_PY_LSB +: LR_FIELD_W] = LR_FIELD_W'(pt_y);
		m_tdata[LR_PC_LSB +: LR_COLOR_W] = pt_color;
	end

	assign m_tlast = stat.last;

	// Never take a request while a point is on offer
	`ASSERT_IMPLIES(a_ready_excl, clk, arst_n, s_tready, !m_tvalid)
	// A loaded request offers its first point in the next cycle
	`ASSERT_NEXT(a_load_emit, clk, arst_n, s_tvalid && s_tready, m_tvalid)
	// Taking the final point frees the block for the next request
	`ASSERT_NEXT(a_last_idle, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

`default_nettype wire

/* hw/rtl/lr_ctrl.sv */
// Controller state machine of the line rasterizer.
`default_nettype none

module lr_ctrl
	import lr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	output logic          pt_valid,
	input  wire logic     pt_ready,
	output lr_cmd_t       cmd,
	input  wire lr_stat_t stat
);

	lr_state_t state_q;
	lr_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LR_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			LR_IDLE: begin
				if (req_valid) state_nxt = LR_EMIT;
			end
			LR_EMIT: begin
				if (pt_ready && stat.last) state_nxt = LR_IDLE;
			end
			default: state_nxt = LR_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		pt_valid  = 1'b0;
		cmd       = '0;
		case (state_q)
			LR_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			LR_EMIT: begin
				pt_valid = 1'b1;
				// advance only when the point is taken and more remain
				cmd.step = pt_ready && !stat.last;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/lr_datapath.sv */
// Datapath of the line rasterizer: endpoint, delta and error registers.
`default_nettype none

module lr_datapath
	import lr_pkg::*;
#(
	parameter int COORD_BITS = 6
) (
	input  wire logic                  clk,
	input  wire lr_cmd_t               cmd,
	output lr_stat_t                   stat,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	input  wire logic [LR_COLOR_W-1:0] pen_color,
	output logic [COORD_BITS-1:0]      point_x,
	output logic [COORD_BITS-1:0]      point_y,
	output logic [LR_COLOR_W-1:0]      point_color
);

	localparam int ERR_W = COORD_BITS + 3;

	logic [COORD_BITS-1:0] x_q, y_q, ex_q, ey_q, dx_q, dy_q;
	logic [LR_COLOR_W-1:0] color_q;
	logic                  xneg_q, yneg_q, xmaj_q;
	logic [ERR_W-1:0]      err_q;

	logic [COORD_BITS-1:0] dx_ld, dy_ld;
	logic                  xmaj_ld;
	logic [ERR_W-1:0]      err_ld;
	logic [ERR_W-1:0]      dmaj2, dmin2, err_nxt;
	logic                  minor_step, x_step, y_step;

	// Load: absolute deltas, major axis and initial error
	always_comb begin
		dx_ld   = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
		dy_ld   = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
		xmaj_ld = dx_ld > dy_ld;
		if (xmaj_ld) begin
			err_ld = {2'b00, dy_ld, 1'b0} - {3'b000, dx_ld};
		end else begin
			err_ld = {2'b00, dx_ld, 1'b0} - {3'b000, dy_ld};
		end
	end

	// Step: major axis always moves, minor axis when the error is not negative
	always_comb begin
		dmaj2      = xmaj_q ? {2'b00, dx_q, 1'b0} : {2'b00, dy_q, 1'b0};
		dmin2      = xmaj_q ? {2'b00, dy_q, 1'b0} : {2'b00, dx_q, 1'b0};
		minor_step = !err_q[ERR_W-1];
		err_nxt    = err_q + dmin2 - (minor_step ? dmaj2 : '0);
		x_step     = xmaj_q || minor_step;
		y_step     = !xmaj_q || minor_step;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= start_x;
			y_q     <= start_y;
			ex_q    <= end_x;
			ey_q    <= end_y;
			dx_q    <= dx_ld;
			dy_q    <= dy_ld;
			xneg_q  <= end_x < start_x;
			yneg_q  <= end_y < start_y;
			xmaj_q  <= xmaj_ld;
			err_q   <= err_ld;
			color_q <= pen_color;
		end else if (cmd.step) begin
			if (x_step) x_q <= xneg_q ? x_q - 1'b1 : x_q + 1'b1;
			if (y_step) y_q <= yneg_q ? y_q - 1'b1 : y_q + 1'b1;
			err_q <= err_nxt;
		end
	end

	assign stat.last   = xmaj_q ? (x_q == ex_q) : (y_q == ey_q);
	assign point_x     = x_q;
	assign point_y     = y_q;
	assign point_color = color_q;

endmodule

`default_nettype wire
